// ----- rtl/ssw_pkg.sv -----
// Shared constants, types and font tables for the seven-segment cached writer.
`default_nettype none

package ssw_pkg;

    localparam int DIGIT_COUNT = 8;
    localparam int IDX_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

    typedef logic [7:0]       seg_t;
    typedef logic [7:0]       char_t;
    typedef logic [3:0]       digit_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam seg_t POINT_BIT     = 8'h80;
    localparam seg_t MINUS_PATTERN = 8'h01;
    localparam seg_t CARET_PATTERN = 8'h63;
    localparam seg_t BLANK_PATTERN = 8'h00;

    localparam char_t CHAR_MINUS = 8'h2D;
    localparam char_t CHAR_CARET = 8'h5E;

    localparam seg_t DIGIT_FONT [10] = '{
        8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
    };

    localparam seg_t LETTER_FONT [26] = '{
        8'h77, 8'h1F, 8'h4E, 8'h3D, 8'h4F, 8'h47, 8'h5E, 8'h37, 8'h30, 8'h38,
        8'h07, 8'h0E, 8'h56, 8'h15, 8'h7E, 8'h67, 8'h73, 8'h05, 8'h5B, 8'h0F,
        8'h3E, 8'h1C, 8'h2A, 8'h37, 8'h3B, 8'h6D
    };

endpackage

`default_nettype wire

// ----- rtl/ssw_glyph.sv -----
// ASCII to segment pattern decoder with decimal point merge.
`default_nettype none

module ssw_glyph (
    input  wire ssw_pkg::char_t code,
    input  wire logic           dp,
    output ssw_pkg::seg_t       seg
);

    logic          is_digit;
    logic          is_upper;
    logic          is_lower;
    logic [3:0]    digit_idx;
    logic [4:0]    letter_idx;
    ssw_pkg::seg_t base;

    assign is_digit = (code >= 8'h30) && (code <= 8'h39);
    assign is_upper = (code >= 8'h41) && (code <= 8'h5A);
    assign is_lower = (code >= 8'h61) && (code <= 8'h7A);

    // 'A' and 'a' both have 5'b00001 in the low bits
    assign digit_idx  = code[3:0];
    assign letter_idx = 5'(code[4:0] - 5'd1);

    always_comb
    begin
        if (is_digit)
        begin
            base = ssw_pkg::DIGIT_FONT[digit_idx];
        end
        else if (is_upper || is_lower)
        begin
            base = ssw_pkg::LETTER_FONT[letter_idx];
        end
        else if (code == ssw_pkg::CHAR_MINUS)
        begin
            base = ssw_pkg::MINUS_PATTERN;
        end
        else if (code == ssw_pkg::CHAR_CARET)
        begin
            base = ssw_pkg::CARET_PATTERN;
        end
        else
        begin
            base = ssw_pkg::BLANK_PATTERN;
        end
    end

    assign seg = dp ? (base | ssw_pkg::POINT_BIT) : base;

endmodule

`default_nettype wire

// ----- rtl/seven_segment_cached_writer.sv -----
// Top level: cached write filter in front of a seven-segment digit driver.
`default_nettype none

// An accepted item sits in the input register, where it is checked against
// the per-slot character cache and point mask and, if it changes the
// display, turned into one driver register write held in the output
// register. Writes that change nothing or name a slot beyond the digit count
// produce no transfer. A new write item is taken every cycle while the output
// side keeps up and no clear burst is draining. A clear item resets the
// cache at once and then streams one blank write per digit, rightmost first,
// from the output register; it leaves the input register when accepted, but
// the next item that writes waits there until the burst's last beat is taken,
// since the output register is the only buffer for the burst.

module seven_segment_cached_writer (
    input  wire logic           clk,
    input  wire logic           rst_n,

    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           operation,
    input  wire logic [3:0]     position,
    input  wire logic [7:0]     character,
    input  wire logic           decimal_point,

    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [3:0]          digit_register,
    output logic [7:0]          segment_bits,
    output logic                last
);

    // input register
    logic                   iv_reg;
    logic                   op_reg;
    logic [3:0]             slot_reg;
    ssw_pkg::char_t         code_reg;
    logic                   dp_reg;

    // display cache
    ssw_pkg::char_t         shown_reg [ssw_pkg::DIGIT_COUNT];
    logic [ssw_pkg::DIGIT_COUNT-1:0] point_reg;

    // output register
    logic                   ov_reg;
    logic                   ov_next;
    ssw_pkg::digit_t        digit_reg;
    ssw_pkg::digit_t        digit_next;
    ssw_pkg::seg_t          seg_reg;
    ssw_pkg::seg_t          seg_next;
    logic                   last_reg;
    logic                   last_next;

    ssw_pkg::idx_t          idx;
    logic                   in_range;
    logic                   hit;
    logic                   emit;
    logic                   out_free;
    logic                   consume;
    logic                   in_xfer;
    ssw_pkg::seg_t          glyph;
    ssw_pkg::digit_t        digit_inc;

    assign idx      = slot_reg[ssw_pkg::IDX_W-1:0];
    assign in_range = slot_reg < 4'(ssw_pkg::DIGIT_COUNT);
    assign hit      = (shown_reg[idx] == code_reg) && (point_reg[idx] == dp_reg);
    assign emit     = (op_reg == ssw_pkg::OP_CLEAR) || (in_range && !hit);

    // output register frees up when empty or when its final beat is taken
    assign out_free = !ov_reg || (out_ready && last_reg);
    assign consume  = iv_reg && (!emit || out_free);
    assign in_ready = !iv_reg || consume;
    assign in_xfer  = in_valid && in_ready;

    assign digit_inc = 4'(digit_reg + 4'd1);

    ssw_glyph u_glyph (
        .code (code_reg),
        .dp   (dp_reg),
        .seg  (glyph)
    );

    always_comb
    begin
        ov_next    = ov_reg;
        digit_next = digit_reg;
        seg_next   = seg_reg;
        last_next  = last_reg;
        if (consume && emit)
        begin
            ov_next = 1'b1;
            if (op_reg == ssw_pkg::OP_CLEAR)
            begin
                digit_next = 4'd1;
                seg_next   = ssw_pkg::BLANK_PATTERN;
                last_next  = (ssw_pkg::DIGIT_COUNT == 1);
            end
            else
            begin
                digit_next = 4'(4'(ssw_pkg::DIGIT_COUNT) - slot_reg);
                seg_next   = glyph;
                last_next  = 1'b1;
            end
        end
        else if (ov_reg && out_ready)
        begin
            if (last_reg)
            begin
                ov_next = 1'b0;
            end
            else
            begin
                // next beat of a clear burst
                digit_next = digit_inc;
                seg_next   = ssw_pkg::BLANK_PATTERN;
                last_next  = (digit_inc == 4'(ssw_pkg::DIGIT_COUNT));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            last_reg  <= 1'b0;
            point_reg <= '0;
            for (int i = 0; i < ssw_pkg::DIGIT_COUNT; i++)
            begin
                shown_reg[i] <= '0;
            end
        end
        else
        begin
            if (in_xfer)
            begin
                iv_reg <= 1'b1;
            end
            else if (consume)
            begin
                iv_reg <= 1'b0;
            end

            ov_reg   <= ov_next;
            last_reg <= last_next;

            if (consume && (op_reg == ssw_pkg::OP_CLEAR))
            begin
                point_reg <= '0;
                for (int i = 0; i < ssw_pkg::DIGIT_COUNT; i++)
                begin
                    shown_reg[i] <= '0;
                end
            end
            else if (consume && emit)
            begin
                shown_reg[idx] <= code_reg;
                point_reg[idx] <= dp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= operation;
            slot_reg <= position;
            code_reg <= character;
            dp_reg   <= decimal_point;
        end
        digit_reg <= digit_next;
        seg_reg   <= seg_next;
    end

    assign out_valid      = ov_reg;
    assign digit_register = digit_reg;
    assign segment_bits   = seg_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire
